>>> design/vlmr_pkg.sv
// Shared types and codes for the variable-length message ring.
// Used by variable_length_message_ring_core, vlmr_ring_checker and testbench; no dependencies.
package vlmr_pkg;

   localparam int LEN_W    = 13;
   localparam int OFFSET_W = 12;
   localparam int STATUS_W = 2;

   localparam logic KIND_RESERVE = 1'b0;
   localparam logic KIND_READ    = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_CROSS  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd3;

   typedef struct packed {
      logic             kind;
      logic [LEN_W-1:0] payload_len;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OFFSET_W-1:0] slab_offset;
      logic [LEN_W-1:0]    slab_payload_len;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

endpackage

>>> design/vlmr_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module vlmr_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 512,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/variable_length_message_ring_core.sv
// Top level of the variable-length message ring allocator.
// Depends on vlmr_pkg and vlmr_ram.
//
// Single-producer single-consumer ring that hands out aligned slabs of header plus payload.
// A reserve transfer writes the payload length into the slot length RAM and registers its
// result from ST_IDLE; a read transfer passes on through ST_READ, because the slot length
// comes from the RAM's registered read port (an empty read answers from ST_IDLE). One item
// is in work at a time; the next item enters in the cycle the waiting result is taken, so a
// stalled result holds off the input. BUFFER_BYTES and ALIGN_BYTES must be powers of two. The
// slot length RAM needs no clearing after reset.
module variable_length_message_ring_core
   import vlmr_pkg::*;
#(
   parameter int BUFFER_BYTES = 4096,
   parameter int ALIGN_BYTES  = 8,
   parameter int HEADER_BYTES = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int PW    = $clog2(BUFFER_BYTES) + 1;
   localparam int OW    = PW - 1;
   localparam int AL    = $clog2(ALIGN_BYTES);
   localparam int SW    = ((PW > LEN_W + 1) ? PW : LEN_W + 1) + 2;
   localparam int SLOTS = BUFFER_BYTES / ALIGN_BYTES;
   localparam int SAW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [SW-1:0] ALIGN_MASK = ~(SW'(ALIGN_BYTES - 1));
   localparam logic [SW-1:0] BUF_SIZE   = SW'(BUFFER_BYTES);

   function automatic logic [SW-1:0] slab_size(input logic [LEN_W-1:0] len);
      logic [SW-1:0] raw;
      raw = SW'(HEADER_BYTES) + SW'(len);
      return (raw + SW'(ALIGN_BYTES - 1)) & ALIGN_MASK;
   endfunction

   state_type     state_ff, state_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [PW-1:0] cons_ff, cons_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_load;

   logic          out_free;
   logic          accept;
   logic          empty;
   logic [PW-1:0] used;
   logic [OW-1:0] prod_off;
   logic [OW-1:0] cons_off;
   logic [SW-1:0] rsv_total;
   logic [SW-1:0] rd_total;
   logic          too_full;
   logic          crosses;

   logic             mem_wr_en;
   logic             mem_rd_en;
   logic [LEN_W-1:0] mem_rd_data;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign empty     = (cons_ff == prod_ff);
   assign used      = prod_ff - cons_ff;
   assign prod_off  = prod_ff[OW-1:0];
   assign cons_off  = cons_ff[OW-1:0];
   assign rsv_total = slab_size(req_data.payload_len);
   assign rd_total  = slab_size(mem_rd_data);
   assign too_full  = (SW'(used) + rsv_total) > BUF_SIZE;
   assign crosses   = (SW'(prod_off) + rsv_total) > BUF_SIZE;

   vlmr_ram #(
      .WIDTH (LEN_W),
      .DEPTH (SLOTS),
      .AW    (SAW)
   ) u_slot_len (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (SAW'(prod_off >> AL)),
      .wr_data (req_data.payload_len),
      .rd_en   (mem_rd_en),
      .rd_addr (SAW'(cons_off >> AL)),
      .rd_data (mem_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.kind == KIND_READ && !empty) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_stall    = 1'b1;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      rsp_load     = 1'b0;
      rsp_in       = '0;
      prod_in      = prod_ff;
      cons_in      = cons_ff;
      case (state_ff)
         ST_IDLE: begin
            req_stall = !out_free;
            if (accept) begin
               if (req_data.kind == KIND_RESERVE) begin
                  rsp_load = 1'b1;
                  if (too_full) begin
                     rsp_in.status = STATUS_FULL;
                  end else if (crosses) begin
                     rsp_in.status = STATUS_CROSS;
                  end else begin
                     mem_wr_en               = 1'b1;
                     prod_in                 = prod_ff + PW'(rsv_total);
                     rsp_in.status           = STATUS_OK;
                     rsp_in.slab_offset      = OFFSET_W'(prod_off);
                     rsp_in.slab_payload_len = req_data.payload_len;
                  end
               end else if (empty) begin
                  rsp_load      = 1'b1;
                  rsp_in.status = STATUS_EMPTY;
               end else begin
                  mem_rd_en = 1'b1;
               end
            end
         end
         ST_READ: begin
            rsp_load                = 1'b1;
            cons_in                 = cons_ff + PW'(rd_total);
            rsp_in.status           = STATUS_OK;
            rsp_in.slab_offset      = OFFSET_W'(cons_off);
            rsp_in.slab_payload_len = mem_rd_data;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prod_ff      <= '0;
         cons_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prod_ff      <= prod_in;
         cons_ff      <= cons_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> sim/vlmr_ring_checker.sv
// Checker for variable_length_message_ring_core: watches both channels, predicts each result
// from its own copy of the ring positions and slot lengths, and compares in order.
// Depends on vlmr_pkg.
module vlmr_ring_checker
   import vlmr_pkg::*;
#(
   parameter int BUFFER_BYTES = 4096,
   parameter int ALIGN_BYTES  = 8,
   parameter int HEADER_BYTES = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POS_W = $clog2(2 * BUFFER_BYTES);

   logic [POS_W-1:0] prod_pos;
   logic [POS_W-1:0] cons_pos;
   logic [LEN_W-1:0] slot_len [BUFFER_BYTES / ALIGN_BYTES];
   rsp_type          expected_q [$];
   int               mismatches = 0;

   function automatic int unsigned slab_size(input logic [LEN_W-1:0] len);
      return ((HEADER_BYTES + len + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
   endfunction

   function automatic rsp_type predict_slab(input req_type item);
      rsp_type          res;
      int unsigned      need;
      int unsigned      off;
      logic [POS_W-1:0] used;
      res  = '0;
      used = prod_pos - cons_pos;
      if (item.kind == KIND_RESERVE) begin
         need = slab_size(item.payload_len);
         off  = prod_pos & (BUFFER_BYTES - 1);
         if (used + need > BUFFER_BYTES) begin
            res.status = STATUS_FULL;
         end else if (off + need > BUFFER_BYTES) begin
            res.status = STATUS_CROSS;
         end else begin
            res.status           = STATUS_OK;
            res.slab_offset      = off[OFFSET_W-1:0];
            res.slab_payload_len = item.payload_len;
            slot_len[off / ALIGN_BYTES] = item.payload_len;
            prod_pos = prod_pos + need[POS_W-1:0];
         end
      end else if (cons_pos == prod_pos) begin
         res.status = STATUS_EMPTY;
      end else begin
         off                  = cons_pos & (BUFFER_BYTES - 1);
         res.status           = STATUS_OK;
         res.slab_offset      = off[OFFSET_W-1:0];
         res.slab_payload_len = slot_len[off / ALIGN_BYTES];
         need                 = slab_size(res.slab_payload_len);
         cons_pos = cons_pos + need[POS_W-1:0];
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         prod_pos = '0;
         cons_pos = '0;
         expected_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: unexpected result status=%0d offset=%0d len=%0d", $realtime,
                           rsp_data.status, rsp_data.slab_offset, rsp_data.slab_payload_len);
               mismatches++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.status !== want.status ||
                   rsp_data.slab_offset !== want.slab_offset ||
                   rsp_data.slab_payload_len !== want.slab_payload_len) begin
                  if (mismatches < 10)
                     $display("%0t: mismatch expected status=%0d offset=%0d len=%0d,",
                              $realtime, want.status, want.slab_offset,
                              want.slab_payload_len,
                              " got status=%0d offset=%0d len=%0d",
                              rsp_data.status, rsp_data.slab_offset,
                              rsp_data.slab_payload_len);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_q.push_back(predict_slab(req_data));
      end
      fail_count    <= mismatches;
      pending_count <= expected_q.size();
   end

endmodule

>>> sim/testbench.sv
// Top of the variable_length_message_ring_core testbench: clock, reset, stimulus,
// random idling on both sides and the verdict. Depends on vlmr_pkg, the core and vlmr_ring_checker.
module testbench
   import vlmr_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BUFFER_BYTES = 4096;
   localparam int ALIGN_BYTES  = 8;
   localparam int HEADER_BYTES = 8;
   localparam int STALL_LIMIT  = 4000;
   localparam int HOLD_CYCLES  = 300;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;

   int      send_idle_pct = 12;
   int      recv_idle_pct = 49;
   logic    hold_req      = 1'b0;
   logic    hold_done     = 1'b0;
   int      hold_left     = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   variable_length_message_ring_core #(
      .BUFFER_BYTES(BUFFER_BYTES),
      .ALIGN_BYTES (ALIGN_BYTES),
      .HEADER_BYTES(HEADER_BYTES)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   vlmr_ring_checker #(
      .BUFFER_BYTES(BUFFER_BYTES),
      .ALIGN_BYTES (ALIGN_BYTES),
      .HEADER_BYTES(HEADER_BYTES)
   ) ring_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .fail_count   (fail_count),
      .pending_count(pending_count)
   );

   // receiver side; one long hold-off when requested
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_req && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("variable_length_message_ring_core verification failed");
      $finish;
   end

   task automatic send_item(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic reserve_slab(input int len);
      req_type item;
      item.kind        = KIND_RESERVE;
      item.payload_len = len[LEN_W-1:0];
      send_item(item);
   endtask

   task automatic read_slab();
      req_type item;
      item.kind        = KIND_READ;
      item.payload_len = LEN_W'($urandom_range(8191));
      send_item(item);
   endtask

   function automatic logic [LEN_W-1:0] pick_len();
      int r;
      r = $urandom_range(99);
      if (r < 60)
         return LEN_W'($urandom_range(160));
      else if (r < 85)
         return LEN_W'($urandom_range(1024));
      else if (r < 95)
         return LEN_W'($urandom_range(4096));
      else
         return LEN_W'($urandom_range(8191));
   endfunction

   // bursts lean toward reserves or reads so the ring fills, drains and wraps
   task automatic random_traffic(input int count);
      req_type item;
      int      left;
      int      burst;
      int      reserve_pct;
      left = count;
      while (left > 0) begin
         burst       = $urandom_range(40, 4);
         reserve_pct = $urandom_range(1) ? 80 : 25;
         while (burst > 0 && left > 0) begin
            item.kind        = ($urandom_range(99) < reserve_pct) ? KIND_RESERVE : KIND_READ;
            item.payload_len = pick_len();
            send_item(item);
            burst--;
            left--;
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      read_slab();
      reserve_slab(0);
      read_slab();
      reserve_slab(4088);   // crosses the buffer end
      reserve_slab(8191);   // full and crossing: full wins
      reserve_slab(4096);
      reserve_slab(4080);   // ends exactly at the buffer end
      read_slab();
      reserve_slab(4088);   // fills the whole ring
      reserve_slab(0);
      read_slab();
      read_slab();
      reserve_slab(1);
      reserve_slab(7);
      reserve_slab(9);
      reserve_slab(4095);
      read_slab();
      read_slab();
      read_slab();
      read_slab();

      random_traffic(290);
      send_idle_pct <= 49;
      recv_idle_pct <= 12;
      random_traffic(300);
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      hold_req      <= 1'b1;
      random_traffic(300);

      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (pending_count != 0);
      repeat (10) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("variable_length_message_ring_core verification clean");
      else
         $display("variable_length_message_ring_core verification failed");
      $finish;
   end

endmodule
